// File: hdl/integer_literal_parser_defines.svh
// Assertion macros for the integer literal parser.
// Included by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef INTEGER_LITERAL_PARSER_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define ILP_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("integer_literal_parser check failed");
// next-cycle implication
`define ILP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("integer_literal_parser check failed");
`else
`define ILP_ASSERT(lbl, ante, cons)
`define ILP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/ilp_pkg.sv
// Package for the integer literal parser: parse state, step result, codes, characters.
// No dependencies.
package ilp_pkg;

	localparam int unsigned MAX_CHARS = 19;
	localparam int unsigned CNT_W     = $clog2(MAX_CHARS + 1);

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_MANY = 2'd2;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HI = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef enum logic [2:0] {
		PH_START = 3'b001,
		PH_ZERO  = 3'b010,
		PH_BODY  = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_BIN = 2'd1,
		RX_OCT = 2'd2,
		RX_HEX = 2'd3
	} radix_t;

	typedef enum logic [2:0] {
		PC_NONE   = 3'd0,
		PC_SIGN   = 3'd1,
		PC_PREFIX = 3'd2,
		PC_DIGIT  = 3'd3,
		PC_UNDER  = 3'd4,
		PC_ZLEAD  = 3'd5
	} pclass_t;

	typedef struct packed {
		phase_t            phase;
		radix_t            radix;
		logic              neg;
		logic [63:0]       mag;
		logic              ovf;
		pclass_t           prev;
		logic [CNT_W-1:0]  count;
	} parse_state_t;

	typedef struct packed {
		logic               emit;
		logic [1:0]         status;
		logic signed [63:0] value;
		logic               pushed_back;
	} step_result_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_START,
		radix: RX_DEC,
		neg:   1'b0,
		mag:   64'd0,
		ovf:   1'b0,
		prev:  PC_NONE,
		count: '0
	};

endpackage

// File: hdl/ilp_in_if.sv
// Character channel of the integer literal parser: valid/ready with ch and at_end.
// No dependencies.
interface ilp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       at_end;

	modport source (output valid, output ch, output at_end, input ready);
	modport sink (input valid, input ch, input at_end, output ready);
endinterface

// File: hdl/ilp_out_if.sv
// Result channel of the integer literal parser: valid/ready with status, value, pushed_back.
// No dependencies.
interface ilp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [63:0] value;
	logic               pushed_back;

	modport source (output valid, output status, output value, output pushed_back, input ready);
	modport sink (input valid, input status, input value, input pushed_back, output ready);
endinterface

// File: hdl/ilp_step.sv
// Next-state and result logic for one character of the integer literal parser.
// Depends on ilp_pkg.
module ilp_step (
	input  ilp_pkg::parse_state_t st,
	input  logic [7:0]            ch,
	input  logic                  at_end,
	output ilp_pkg::parse_state_t nxt,
	output ilp_pkg::step_result_t res
);
	import ilp_pkg::*;

	localparam logic [67:0] LIMIT_MAG = {4'b0, 1'b1, 63'b0};

	logic         term;
	logic         raw_ok;
	logic [3:0]   raw_d;
	logic         dig_ok;
	logic [67:0]  scaled;
	logic [67:0]  acc;
	parse_state_t body_nxt;
	step_result_t body_res;
	step_result_t bad_res;

	assign term = !at_end && (ch == CH_HASH || ch == CH_COMMA || ch == CH_RBRK ||
		ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_NL);

	assign bad_res = '{emit: 1'b1, status: ST_BAD, value: 64'sd0, pushed_back: 1'b0};

	// digit decode; letters map to 10..15 via their low nibble
	always_comb begin
		raw_ok = 1'b1;
		raw_d  = '0;
		priority if (ch >= CH_0 && ch <= CH_9) begin
			raw_d = ch[3:0];
		end else if ((ch >= CH_LA && ch <= CH_LF_HI) || (ch >= CH_UA && ch <= CH_UF)) begin
			raw_d = ch[3:0] + 4'd9;
		end else begin
			raw_ok = 1'b0;
		end
	end

	always_comb begin
		unique case (st.radix)
			RX_BIN: dig_ok = raw_ok && (raw_d < 4'd2);
			RX_OCT: dig_ok = raw_ok && (raw_d < 4'd8);
			RX_DEC: dig_ok = raw_ok && (raw_d < 4'd10);
			RX_HEX: dig_ok = raw_ok;
			default: dig_ok = 1'b0;
		endcase
	end

	always_comb begin
		unique case (st.radix)
			RX_BIN: scaled = {3'b0, st.mag, 1'b0};
			RX_OCT: scaled = {1'b0, st.mag, 3'b0};
			RX_HEX: scaled = {st.mag, 4'b0};
			RX_DEC: scaled = {1'b0, st.mag, 3'b0} + {3'b0, st.mag, 1'b0};
			default: scaled = '0;
		endcase
	end

	assign acc = scaled + {64'b0, raw_d};

	// digit or underscore inside the body
	always_comb begin
		body_nxt       = st;
		body_nxt.phase = PH_BODY;
		body_res       = '0;
		priority if (ch == CH_UNDER) begin
			if (st.prev != PC_DIGIT) begin
				body_res = bad_res;
			end else begin
				body_nxt.prev = PC_UNDER;
			end
		end else if (!dig_ok || st.prev == PC_ZLEAD) begin
			body_res = bad_res;
		end else if (st.count >= CNT_W'(MAX_CHARS)) begin
			body_res = '{emit: 1'b1, status: ST_MANY, value: 64'sd0, pushed_back: 1'b0};
		end else begin
			body_nxt.count = CNT_W'(st.count + 1'b1);
			if (!st.ovf) begin
				if (acc > LIMIT_MAG) begin
					body_nxt.ovf = 1'b1;
				end else begin
					body_nxt.mag = acc[63:0];
				end
			end
			body_nxt.prev = (st.radix == RX_DEC && st.prev == PC_SIGN && raw_d == 4'd0) ?
				PC_ZLEAD : PC_DIGIT;
		end
		if (body_res.emit) begin
			body_nxt = STATE_RESET;
		end
	end

	always_comb begin
		nxt = st;
		res = '0;
		unique case (st.phase)
			PH_START: begin
				priority if (at_end || term) begin
					res             = bad_res;
					res.pushed_back = term;
				end else if (ch == CH_PLUS) begin
					nxt.prev  = PC_SIGN;
					nxt.phase = PH_BODY;
				end else if (ch == CH_MINUS) begin
					nxt.neg   = 1'b1;
					nxt.count = CNT_W'(1);
					nxt.prev  = PC_SIGN;
					nxt.phase = PH_BODY;
				end else if (ch == CH_0) begin
					nxt.phase = PH_ZERO;
				end else if (ch >= CH_1 && ch <= CH_9) begin
					nxt = body_nxt;
					res = body_res;
				end else begin
					res = bad_res;
				end
			end
			PH_ZERO: begin
				priority if (at_end || term) begin
					res = '{emit: 1'b1, status: ST_OK, value: 64'sd0, pushed_back: term};
				end else if (ch == CH_B || ch == CH_O || ch == CH_X) begin
					nxt.radix = (ch == CH_B) ? RX_BIN : (ch == CH_O) ? RX_OCT : RX_HEX;
					nxt.prev  = PC_PREFIX;
					nxt.phase = PH_BODY;
				end else begin
					res = bad_res;
				end
			end
			PH_BODY: begin
				if (at_end || term) begin
					res.emit        = 1'b1;
					res.pushed_back = term;
					// value only kept when digits ended cleanly and within range
					if ((st.prev != PC_DIGIT && st.prev != PC_ZLEAD) || st.ovf ||
						(!st.neg && st.mag == LIMIT_MAG[63:0])) begin
						res.status = ST_BAD;
					end else begin
						res.status = ST_OK;
						res.value  = st.neg ? $signed(~st.mag + 64'd1) : $signed(st.mag);
					end
				end else begin
					nxt = body_nxt;
					res = body_res;
				end
			end
			default: begin
				res = '0;
			end
		endcase
		if (res.emit || (st.phase != PH_START && st.phase != PH_ZERO && st.phase != PH_BODY)) begin
			nxt = STATE_RESET;
		end
	end

endmodule

// File: hdl/integer_literal_parser.sv
// A character waits in the input register; its result, if any, enters the result register.
// Throughput: one character per cycle unless a result waits on an unread result register; the
// parse state loop (digit scale-add and overflow compare) is combinational between these registers.
// Reset: arst_n clears the input stage, the parse state and the result valid flag at once.
// Depends on ilp_pkg, ilp_in_if, ilp_out_if, ilp_step and integer_literal_parser_defines.svh.
`include "integer_literal_parser_defines.svh"

module integer_literal_parser (
	input logic      clk,
	input logic      arst_n,
	ilp_in_if.sink   chars,
	ilp_out_if.source results
);
	import ilp_pkg::*;

	logic               valid_s1;
	logic [7:0]         ch_s1;
	logic               at_end_s1;
	parse_state_t       state_q;
	parse_state_t       state_nxt;
	step_result_t       step_res;
	logic               proc;
	logic               res_valid_q;
	logic [1:0]         res_status_q;
	logic signed [63:0] res_value_q;
	logic               res_pb_q;

	ilp_step u_step (
		.st     (state_q),
		.ch     (ch_s1),
		.at_end (at_end_s1),
		.nxt    (state_nxt),
		.res    (step_res)
	);

	// a character with no result never waits on the output register
	assign proc        = valid_s1 && (!res_valid_q || results.ready || !step_res.emit);
	assign chars.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1     <= chars.ch;
			at_end_s1 <= chars.at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (proc) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc && step_res.emit) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && step_res.emit) begin
			res_status_q <= step_res.status;
			res_value_q  <= step_res.value;
			res_pb_q     <= step_res.pushed_back;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.status      = res_status_q;
	assign results.value       = res_value_q;
	assign results.pushed_back = res_pb_q;

	`ILP_ASSERT_NEXT(a_s1_hold, valid_s1 && !proc, valid_s1 && $stable(ch_s1) && $stable(at_end_s1))
	`ILP_ASSERT_NEXT(a_emit_clears, proc && step_res.emit, state_q.phase == PH_START)
	`ILP_ASSERT(a_start_clean, state_q.phase == PH_START, state_q.mag == 64'd0 && !state_q.ovf && !state_q.neg)

endmodule
